>>> hw/rtl/mgrs_pkg.sv
// ----------------------------------------------------------------------------
// mgrs_pkg
// Shared types and constants of the multichannel gain ramp smoother.
// ----------------------------------------------------------------------------
package mgrs_pkg;

  // field widths
  localparam int unsigned CH_W       = 5;
  localparam int unsigned SMP_W      = 24;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned RF_W       = 16;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned FRAC_EXTRA = 16;
  localparam int unsigned CUR_W      = GAIN_W + FRAC_EXTRA;
  localparam int unsigned STEP_W     = CUR_W + 1;
  localparam int unsigned MAX_CH     = 32;

  // queue depths
  localparam int unsigned IN_DEPTH  = 4;
  localparam int unsigned IN_AW     = $clog2(IN_DEPTH);
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = RF_W;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FRAMES   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 4'd1;
  localparam logic [RF_W-1:0]  RAMP_FRAMES_RESET   = 16'd480;
  localparam logic [CNT_W-1:0] CHANNEL_COUNT_RESET = 6'd2;

  // item opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_SET    = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [CH_W-1:0]          channel;
    logic signed [SMP_W-1:0]  sample;
    logic [GAIN_W-1:0]        target_gain;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]  sample_out;
    logic [CH_W-1:0]          out_channel;
    logic [GAIN_W-1:0]        gain_used;
  } out_item_t;

  // classified request handed from front to engine
  typedef struct packed {
    logic                     is_set;
    logic [CH_W-1:0]          channel;
    logic signed [SMP_W-1:0]  sample;
    logic [GAIN_W-1:0]        target_gain;
  } cmd_t;

  typedef struct packed {
    logic [RF_W-1:0]  ramp_frames;
    logic [CNT_W-1:0] channel_count;
  } cfg_t;

endpackage

>>> hw/rtl/mgrs_front.sv
// ----------------------------------------------------------------------------
// mgrs_front
// Input queue: accepts requests, classifies them and holds them for the engine.
// ----------------------------------------------------------------------------
module mgrs_front import mgrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  output logic     full_o,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o,
  input  logic     cmd_pop_i
);

  cmd_t             mem_q [IN_DEPTH];
  logic [IN_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IN_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [IN_AW:0]   cnt_q, cnt_d;
  logic             wr_en, rd_en;
  cmd_t             cmd_new;

  // classify the incoming request
  always_comb begin
    cmd_new.is_set      = (in_item_i.op == OP_SET);
    cmd_new.channel     = in_item_i.channel;
    cmd_new.sample      = in_item_i.sample;
    cmd_new.target_gain = in_item_i.target_gain;
  end

  assign full_o      = (cnt_q == (IN_AW+1)'(IN_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> hw/rtl/mgrs_div.sv
// ----------------------------------------------------------------------------
// mgrs_div
// Restoring unsigned divider, one quotient bit per cycle, for the ramp step.
// ----------------------------------------------------------------------------
module mgrs_div import mgrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [STEP_W-1:0] dividend_i,
  input  logic [RF_W-1:0]   divisor_i,
  output logic              done_o,
  output logic [STEP_W-1:0] quot_o
);

  localparam int unsigned ITER_W = $clog2(STEP_W);

  logic              busy_q;
  logic              done_q;
  logic [ITER_W-1:0] iter_q;
  logic [STEP_W-1:0] dvd_q, dvd_d;
  logic [RF_W-1:0]   rem_q, rem_d;
  logic [RF_W-1:0]   dvs_q;
  logic [RF_W:0]     shifted;
  logic              fits;

  // one restoring step
  always_comb begin
    shifted = {rem_q, dvd_q[STEP_W-1]};
    fits    = (shifted >= {1'b0, dvs_q});
    rem_d   = fits ? RF_W'(shifted - {1'b0, dvs_q}) : shifted[RF_W-1:0];
    dvd_d   = {dvd_q[STEP_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= ITER_W'(STEP_W - 1);
      end else if (busy_q) begin
        iter_q <= iter_q - 1'b1;
        if (iter_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

>>> hw/rtl/mgrs_out_queue.sv
// ----------------------------------------------------------------------------
// mgrs_out_queue
// Result queue between the engine and the result port.
// ----------------------------------------------------------------------------
module mgrs_out_queue import mgrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_item_t item_i,
  output logic      full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t item_o
);

  out_item_t         mem_q [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr_q;
  logic [OUT_AW-1:0] rd_ptr_q;
  logic [OUT_AW:0]   cnt_q;
  logic              wr_en, rd_en;

  assign full_o  = (cnt_q == (OUT_AW+1)'(OUT_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> hw/rtl/mgrs_engine.sv
// ----------------------------------------------------------------------------
// mgrs_engine
// Back end: per-channel gain state, ramp setup, gain advance, multiply and round.
// ----------------------------------------------------------------------------
module mgrs_engine import mgrs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output out_item_t out_item_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_RND  = 2'd2;
  localparam logic [1:0] ST_DIV  = 2'd3;

  localparam int unsigned PROD_W = SMP_W + GAIN_W + 1;
  localparam int unsigned Q_W    = PROD_W - 20;
  localparam logic [CUR_W-1:0]  GAIN_ONE = CUR_W'(1) << (20 + FRAC_EXTRA);
  localparam logic [GAIN_W-1:0] TGT_ONE  = GAIN_W'(1) << 20;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(8388607);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(8388608);

  // per-channel state
  logic [CUR_W-1:0]  cur_q     [MAX_CH];
  logic [GAIN_W-1:0] tgt_q     [MAX_CH];
  logic [STEP_W-1:0] step_q    [MAX_CH];
  logic [RF_W-1:0]   left_q    [MAX_CH];
  logic [MAX_CH-1:0] started_q;
  logic [CH_W-1:0]   ptr_q;

  logic [1:0]        state_q;
  logic [CH_W-1:0]   div_ch_q;
  logic              neg_q;

  // sample pipeline registers
  logic signed [SMP_W-1:0]  smp_q;
  logic [GAIN_W-1:0]        g20_q;
  logic [CH_W-1:0]          och_q;
  logic signed [PROD_W-1:0] prod_q;

  logic [CNT_W-1:0]  eff_cnt;
  logic [CH_W-1:0]   smp_ch;
  logic [CNT_W-1:0]  nxt_ptr;
  logic [CH_W-1:0]   sel_ch;
  logic [CUR_W-1:0]  cur_rd;
  logic [GAIN_W-1:0] tgt_rd;
  logic [STEP_W-1:0] step_rd;
  logic [RF_W-1:0]   left_rd;
  logic              started_rd;
  logic              start, start_smp, start_set;
  logic [CUR_W-1:0]  tgt36_rd, tgt36_new, g36;
  logic [CUR_W:0]    g36_rnd;
  logic [GAIN_W-1:0] g20;
  logic              same_tgt, jump, need_div;
  logic [STEP_W-1:0] diff, mag;
  logic              div_done;
  logic [STEP_W-1:0] quot;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [Q_W-1:0]    q_val;

  // effective channel count and pointer wrap
  always_comb begin
    if (cfg_i.channel_count == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (cfg_i.channel_count > CNT_W'(MAX_CH)) begin
      eff_cnt = CNT_W'(MAX_CH);
    end else begin
      eff_cnt = cfg_i.channel_count;
    end
    smp_ch  = ({1'b0, ptr_q} >= eff_cnt) ? '0 : ptr_q;
    nxt_ptr = {1'b0, smp_ch} + 1'b1;
    if (nxt_ptr >= eff_cnt) begin
      nxt_ptr = '0;
    end
  end

  // channel state read
  assign sel_ch     = cmd_i.is_set ? cmd_i.channel : smp_ch;
  assign cur_rd     = cur_q[sel_ch];
  assign tgt_rd     = tgt_q[sel_ch];
  assign step_rd    = step_q[sel_ch];
  assign left_rd    = left_q[sel_ch];
  assign started_rd = started_q[sel_ch];

  // take a request in the idle state; a sample only once the result side has room
  assign start     = (state_q == ST_IDLE) && cmd_valid_i && (cmd_i.is_set || !out_full_i);
  assign start_smp = start && !cmd_i.is_set;
  assign start_set = start && cmd_i.is_set;
  assign cmd_pop_o = start;

  // gain applied to a sample, rounded to Q4.20 and saturated
  always_comb begin
    tgt36_rd = {tgt_rd, {FRAC_EXTRA{1'b0}}};
    g36      = started_rd ? cur_rd : tgt36_rd;
    g36_rnd  = {1'b0, g36} + (CUR_W+1)'(1 << (FRAC_EXTRA - 1));
    if (g36_rnd[CUR_W:FRAC_EXTRA] > (CUR_W+1-FRAC_EXTRA)'({GAIN_W{1'b1}})) begin
      g20 = {GAIN_W{1'b1}};
    end else begin
      g20 = g36_rnd[FRAC_EXTRA+GAIN_W-1:FRAC_EXTRA];
    end
  end

  // new target classification and ramp difference
  always_comb begin
    tgt36_new = {cmd_i.target_gain, {FRAC_EXTRA{1'b0}}};
    same_tgt  = (cmd_i.target_gain == tgt_rd);
    jump      = (cfg_i.ramp_frames <= RF_W'(1)) || (cur_rd == tgt36_new);
    need_div  = start_set && !same_tgt && started_rd && !jump;
    diff      = {1'b0, tgt36_new} - {1'b0, cur_rd};
    mag       = diff[STEP_W-1] ? (~diff + 1'b1) : diff;
  end

  mgrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (need_div),
    .dividend_i (mag),
    .divisor_i  (cfg_i.ramp_frames - 1'b1),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CH; i++) begin
        cur_q[i]  <= GAIN_ONE;
        tgt_q[i]  <= TGT_ONE;
        step_q[i] <= '0;
        left_q[i] <= '0;
      end
      started_q <= '0;
      ptr_q     <= '0;
      state_q   <= ST_IDLE;
      div_ch_q  <= '0;
      neg_q     <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_smp) begin
            ptr_q   <= nxt_ptr[CH_W-1:0];
            state_q <= ST_MUL;
            if (!started_rd) begin
              started_q[sel_ch] <= 1'b1;
              cur_q[sel_ch]     <= tgt36_rd;
              left_q[sel_ch]    <= '0;
            end else if (left_rd > RF_W'(1)) begin
              cur_q[sel_ch]  <= cur_rd + step_rd[CUR_W-1:0];
              left_q[sel_ch] <= left_rd - 1'b1;
            end else if (left_rd == RF_W'(1)) begin
              cur_q[sel_ch]  <= tgt36_rd;
              left_q[sel_ch] <= '0;
              step_q[sel_ch] <= '0;
            end
          end else if (start_set && !same_tgt) begin
            tgt_q[sel_ch] <= cmd_i.target_gain;
            if (started_rd) begin
              if (jump) begin
                cur_q[sel_ch]  <= tgt36_new;
                left_q[sel_ch] <= '0;
                step_q[sel_ch] <= '0;
              end else begin
                left_q[sel_ch] <= cfg_i.ramp_frames;
                div_ch_q       <= sel_ch;
                neg_q          <= diff[STEP_W-1];
                state_q        <= ST_DIV;
              end
            end
          end
        end
        ST_MUL: begin
          state_q <= ST_RND;
        end
        ST_RND: begin
          state_q <= ST_IDLE;
        end
        ST_DIV: begin
          if (div_done) begin
            step_q[div_ch_q] <= neg_q ? (~quot + 1'b1) : quot;
            state_q          <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // sample datapath
  always_ff @(posedge clk_i) begin
    if (start_smp) begin
      smp_q <= cmd_i.sample;
      g20_q <= g20;
      och_q <= smp_ch;
    end
    if (state_q == ST_MUL) begin
      prod_q <= smp_q * $signed({1'b0, g20_q});
    end
  end

  // round half up and saturate
  always_comb begin
    prod_rnd = prod_q + PROD_W'(1 << 19);
    q_val    = prod_rnd[PROD_W-1:20];
    if (q_val > Q_MAX) begin
      out_item_o.sample_out = Q_MAX[SMP_W-1:0];
    end else if (q_val < Q_MIN) begin
      out_item_o.sample_out = Q_MIN[SMP_W-1:0];
    end else begin
      out_item_o.sample_out = q_val[SMP_W-1:0];
    end
    out_item_o.out_channel = och_q;
    out_item_o.gain_used   = g20_q;
  end

  assign out_push_o = (state_q == ST_RND);

  // checks
  a_no_pop_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !cmd_pop_o)
    else $error("request taken while the divider runs");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_sample_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_smp |-> ##2 out_push_o)
    else $error("sample did not produce a result two cycles later");

  a_room_for_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into a full queue");

endmodule

>>> hw/rtl/multichannel_gain_ramp_smoother_core.sv
// ----------------------------------------------------------------------------
// multichannel_gain_ramp_smoother_core
// Per-channel linear gain smoother for interleaved audio samples.
//
//   channel   handshake          payload
//   input     push_i / full_o    in_item_i  (op, channel, sample, target_gain)
//   result    pop_i / empty_o    out_item_o (sample_out, out_channel, gain_used)
//   config    cfg_we_i           cfg_idx_i, cfg_data_i
//
// A sample goes through gain advance, multiply and round, in that order.
// A set-target request is done in the idle state unless a ramp starts: the
// engine then waits while a one-bit-per-cycle divider finds 41 quotient bits.
// Input and result queues decouple the ports; a long stall on one still stops the other.
// Reset is asynchronous, active low; all channel state is loaded at once.
// ----------------------------------------------------------------------------
module multichannel_gain_ramp_smoother_core import mgrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  in_item_t              in_item_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  logic      cmd_valid;
  cmd_t      cmd;
  logic      cmd_pop;
  logic      out_full;
  logic      out_push;
  out_item_t out_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_frames   <= RAMP_FRAMES_RESET;
      cfg_q.channel_count <= CHANNEL_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RAMP_FRAMES:   cfg_q.ramp_frames   <= cfg_data_i[RF_W-1:0];
        CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: input queue
  mgrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // back: gain engine
  mgrs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_item_o  (out_item)
  );

  // result queue
  mgrs_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .item_i  (out_item),
    .full_o  (out_full),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .item_o  (out_item_o)
  );

endmodule

>>> verif/gain_ramp_checker.sv
// ----------------------------------------------------------------------------
// gain_ramp_checker
// Watches the request, result and register ports of the gain ramp smoother.
// Keeps its own per-channel gain, target and ramp state, predicts every
// sample result and compares the popped results field by field in order.
// ----------------------------------------------------------------------------
module gain_ramp_checker import mgrs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  in_item_t              in_item_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  out_item_t             out_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint OUT_MAX  = (longint'(1) << (SMP_W - 1)) - 1;
  localparam longint OUT_MIN  = -(longint'(1) << (SMP_W - 1));
  localparam longint GAIN_MAX = (longint'(1) << GAIN_W) - 1;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 24'h10_0000;

  // per-channel gain state
  logic [CUR_W-1:0]         gain_acc     [MAX_CH];
  logic [GAIN_W-1:0]        goal_gain    [MAX_CH];
  logic signed [STEP_W-1:0] slope        [MAX_CH];
  logic [RF_W-1:0]          frames_to_go [MAX_CH];
  logic                     started      [MAX_CH];
  logic [CH_W-1:0]          next_ch;

  // register copies
  logic [RF_W-1:0]          ramp_len;
  logic [CNT_W-1:0]         ch_total;

  out_item_t                scaled_q [$];
  int unsigned              misses = 0;

  assign fail_count_o = misses;

  function automatic void clear_gains();
    for (int i = 0; i < MAX_CH; i++) begin
      gain_acc[i]     = CUR_W'(GAIN_UNITY) << FRAC_EXTRA;
      goal_gain[i]    = GAIN_UNITY;
      slope[i]        = '0;
      frames_to_go[i] = '0;
      started[i]      = 1'b0;
    end
    next_ch  = '0;
    ramp_len = RAMP_FRAMES_RESET;
    ch_total = CHANNEL_COUNT_RESET;
  endfunction

  function automatic int unsigned ramp_eff();
    return (ramp_len == 0) ? 1 : ramp_len;
  endfunction

  function automatic int unsigned count_eff();
    if (ch_total == 0) return 1;
    if (ch_total > MAX_CH) return MAX_CH;
    return ch_total;
  endfunction

  // new target: store, then jump or start a ramp on a running channel
  function automatic void retarget(logic [CH_W-1:0] ch, logic [GAIN_W-1:0] tgt);
    logic [CUR_W-1:0] tgt_wide;
    int unsigned      rf;
    longint           diff;
    if (tgt == goal_gain[ch]) return;
    goal_gain[ch] = tgt;
    if (!started[ch]) return;
    tgt_wide = CUR_W'(tgt) << FRAC_EXTRA;
    rf = ramp_eff();
    if (rf <= 1 || gain_acc[ch] == tgt_wide) begin
      gain_acc[ch]     = tgt_wide;
      frames_to_go[ch] = '0;
      slope[ch]        = '0;
      return;
    end
    frames_to_go[ch] = RF_W'(rf);
    diff = longint'(tgt_wide) - longint'(gain_acc[ch]);
    slope[ch] = STEP_W'(diff / longint'(rf - 1));
  endfunction

  // gain for this sample, then one ramp step
  function automatic logic [CUR_W-1:0] step_gain(logic [CH_W-1:0] ch);
    logic [CUR_W-1:0] now;
    if (!started[ch]) begin
      started[ch]      = 1'b1;
      gain_acc[ch]     = CUR_W'(goal_gain[ch]) << FRAC_EXTRA;
      frames_to_go[ch] = '0;
      return gain_acc[ch];
    end
    now = gain_acc[ch];
    if (frames_to_go[ch] > 1) begin
      gain_acc[ch]     = CUR_W'(longint'(gain_acc[ch]) + longint'(slope[ch]));
      frames_to_go[ch] = frames_to_go[ch] - 1'b1;
    end else if (frames_to_go[ch] == 1) begin
      gain_acc[ch]     = CUR_W'(goal_gain[ch]) << FRAC_EXTRA;
      frames_to_go[ch] = '0;
      slope[ch]        = '0;
    end
    return now;
  endfunction

  // sample times gain of the channel under the pointer
  function automatic out_item_t scale_sample(logic signed [SMP_W-1:0] smp);
    int unsigned      n;
    int unsigned      nxt;
    logic [CH_W-1:0]  ch;
    logic [CUR_W-1:0] g36;
    longint           g20;
    longint           prod;
    longint           q;
    out_item_t        res;
    n = count_eff();
    if (next_ch >= n) next_ch = '0;
    ch  = next_ch;
    g36 = step_gain(ch);
    g20 = (longint'(g36) + (longint'(1) << (FRAC_EXTRA - 1))) >>> FRAC_EXTRA;
    if (g20 > GAIN_MAX) g20 = GAIN_MAX;
    prod = longint'(smp) * g20;
    q = (prod + (longint'(1) << 19)) >>> 20;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < OUT_MIN) q = OUT_MIN;
    res.sample_out  = SMP_W'(q);
    res.out_channel = ch;
    res.gain_used   = GAIN_W'(g20);
    nxt = ch + 1;
    next_ch = (nxt >= n) ? '0 : CH_W'(nxt);
    return res;
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t want;
    if (scaled_q.size() == 0) begin
      $error("unexpected result: sample_out %0d out_channel %0d gain_used %06h",
             got.sample_out, got.out_channel, got.gain_used);
      misses++;
      return;
    end
    want = scaled_q.pop_front();
    if (got.sample_out !== want.sample_out) begin
      $error("sample_out mismatch: expected %0d, actual %0d", want.sample_out, got.sample_out);
      misses++;
    end
    if (got.out_channel !== want.out_channel) begin
      $error("out_channel mismatch: expected %0d, actual %0d",
             want.out_channel, got.out_channel);
      misses++;
    end
    if (got.gain_used !== want.gain_used) begin
      $error("gain_used mismatch: expected %06h, actual %06h", want.gain_used, got.gain_used);
      misses++;
    end
  endfunction

  // results are checked before new requests enter the prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_gains();
      scaled_q.delete();
      pending_o <= 0;
    end else begin
      if (pop_i && !empty_i) check_result(out_item_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RAMP_FRAMES:   ramp_len = cfg_data_i;
          CFG_CHANNEL_COUNT: ch_total = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        if (in_item_i.op == OP_SET) retarget(in_item_i.channel, in_item_i.target_gain);
        else scaled_q.insert(scaled_q.size(), scale_sample(in_item_i.sample));
      end
      pending_o <= scaled_q.size();
    end
  end

endmodule

>>> verif/multichannel_gain_ramp_smoother_core_tb.sv
// ----------------------------------------------------------------------------
// multichannel_gain_ramp_smoother_core_tb
// Drives sample and set-target requests into the gain ramp smoother under
// random idle and stall patterns, across many ramp length and channel count
// settings; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module multichannel_gain_ramp_smoother_core_tb import mgrs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time         CLK_PERIOD   = 10ns;
  localparam time         RUN_LIMIT    = 10ms;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned NUM_PHASES   = 16;
  localparam int unsigned PHASE_ITEMS  = 115;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 4'd15;

  localparam logic [GAIN_W-1:0] GAIN_ZERO  = 24'h00_0000;
  localparam logic [GAIN_W-1:0] GAIN_LSB   = 24'h00_0001;
  localparam logic [GAIN_W-1:0] GAIN_HALF  = 24'h08_0000;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 24'h10_0000;
  localparam logic [GAIN_W-1:0] GAIN_TWO   = 24'h20_0000;
  localparam logic [GAIN_W-1:0] GAIN_TOP   = 24'hFF_FFFF;

  localparam logic signed [SMP_W-1:0] SMP_MAX = 24'sh7F_FFFF;
  localparam logic signed [SMP_W-1:0] SMP_MIN = 24'sh80_0000;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  push_i     = 1'b0;
  logic                  full_o;
  in_item_t              in_item_i  = '0;
  logic                  empty_o;
  logic                  pop_i      = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int unsigned           miss_count;
  int unsigned           waiting;
  bit                    steady = 1'b0;
  int unsigned           pop_hold = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  multichannel_gain_ramp_smoother_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_item_i  (in_item_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  gain_ramp_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_i       (full_o),
    .in_item_i    (in_item_i),
    .empty_i      (empty_o),
    .pop_i        (pop_i),
    .out_item_i   (out_item_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (miss_count),
    .pending_o    (waiting)
  );

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned active_channels(logic [CNT_W-1:0] cc);
    if (cc == 0) return 1;
    if (cc > MAX_CH) return MAX_CH;
    return cc;
  endfunction

  function automatic in_item_t make_sample(logic signed [SMP_W-1:0] smp);
    in_item_t it;
    it.op          = OP_SAMPLE;
    it.channel     = CH_W'($urandom);
    it.sample      = smp;
    it.target_gain = GAIN_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_target(logic [CH_W-1:0] ch, logic [GAIN_W-1:0] g);
    in_item_t it;
    it.op          = OP_SET;
    it.channel     = ch;
    it.sample      = SMP_W'($urandom);
    it.target_gain = g;
    return it;
  endfunction

  // small pool so that unchanged targets and repeated levels come up often
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return GAIN_ZERO;
      1: return GAIN_UNITY;
      2: return GAIN_HALF;
      3: return GAIN_TWO;
      4: return GAIN_TOP;
      5: return GAIN_LSB;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return '0;
      3: return -24'sd1;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [RF_W-1:0] pick_ramp();
    case ($urandom_range(0, 5))
      0: return RF_W'($urandom_range(0, 3));
      1, 2: return RF_W'($urandom_range(4, 16));
      3: return RF_W'($urandom_range(17, 100));
      4: return RF_W'($urandom_range(101, 600));
      default: return RF_W'($urandom);
    endcase
  endfunction

  // mostly targets for channels in the frame, some for any channel
  function automatic in_item_t next_request(int unsigned set_pct, int unsigned n_ch);
    logic [CH_W-1:0] ch;
    if ($urandom_range(0, 99) >= set_pct) return make_sample(pick_sample());
    if ($urandom_range(0, 9) == 0) ch = CH_W'($urandom_range(0, MAX_CH - 1));
    else ch = CH_W'($urandom_range(0, n_ch - 1));
    return make_target(ch, pick_gain());
  endfunction

  // result side: pop with random stalls
  always @(posedge clk_i) begin
    if (pop_hold > 0) begin
      pop_hold--;
      pop_i <= 1'b0;
    end else begin
      pop_i <= 1'b1;
      if (!steady && $urandom_range(0, 5) == 0) pop_hold = idle_len();
    end
  end

  // one request, after an optional gap, held until accepted
  task automatic send_req(input in_item_t req);
    int unsigned gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    repeat (gap) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i    <= 1'b1;
    in_item_i <= req;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
  endtask

  // stop sending, wait for every result, then let queued targets finish
  task automatic drain();
    push_i <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // register writes while idle; upper data bits of the count are junk
  task automatic write_regs(input logic [RF_W-1:0] rf, input logic [CNT_W-1:0] cc,
                            input bit poke_unused);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_RAMP_FRAMES;
    cfg_data_i <= rf;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CHANNEL_COUNT;
    cfg_data_i <= {(CFG_DATA_W - CNT_W)'($urandom), cc};
    if (poke_unused) begin
      @(posedge clk_i);
      cfg_idx_i  <= CFG_UNUSED_IDX;
      cfg_data_i <= CFG_DATA_W'($urandom);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [RF_W-1:0]  rf;
    logic [CNT_W-1:0] cc;
    int unsigned      set_pct;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: target before first sample, unchanged target, slow ramps
    send_req(make_target(5'd0, GAIN_HALF));
    send_req(make_sample(SMP_MAX));
    send_req(make_sample(SMP_MIN));
    send_req(make_target(5'd1, GAIN_UNITY));
    send_req(make_target(5'd1, GAIN_TOP));
    send_req(make_sample(SMP_MAX));
    send_req(make_sample(SMP_MIN));
    send_req(make_target(5'd5, GAIN_ZERO));
    send_req(make_target(5'd0, GAIN_ZERO));
    send_req(make_sample(24'sd1));
    send_req(make_sample(-24'sd1));
    send_req(make_sample('0));
    drain();

    // shortest real ramp, channel count above the limit, unused index
    write_regs(16'd2, 6'd33, 1'b1);
    send_req(make_target(5'd1, GAIN_LSB));
    send_req(make_sample(24'sh40_0000));
    send_req(make_sample(SMP_MAX));
    send_req(make_sample(SMP_MIN));
    send_req(make_sample(SMP_MAX));
    drain();

    // zero ramp length and zero channel count: jumps and saturation
    write_regs(16'd0, 6'd0, 1'b0);
    send_req(make_target(5'd0, GAIN_TOP));
    send_req(make_sample(SMP_MAX));
    send_req(make_sample(SMP_MIN));
    drain();

    // random phases, each with its own settings and traffic mix
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin rf = 16'hFFFF; cc = 6'h3F; end
        1: begin rf = 16'd1;    cc = 6'd1;  end
        2: begin rf = 16'd3;    cc = 6'd32; end
        default: begin
          rf = pick_ramp();
          cc = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 8));
        end
      endcase
      case ($urandom_range(0, 2))
        0: set_pct = 5;
        1: set_pct = 20;
        default: set_pct = 40;
      endcase
      write_regs(rf, cc, p == NUM_PHASES - 1);
      steady = (p % 4 == 3);
      for (int k = 0; k < PHASE_ITEMS; k++) send_req(next_request(set_pct, active_channels(cc)));
      drain();
      steady = 1'b0;
    end

    if (miss_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
